### hw/rtl/iaf_pkg.sv
// ----------------------------------------------------------------------------
// Incidence angle package
// Shared widths, constants, stage types and step functions of the incidence
// angle pipeline.
// ----------------------------------------------------------------------------
package iaf_pkg;

    localparam int COORD_W = 32;
    localparam int NORM_W  = 16;
    localparam int RANGE_W = 32;
    localparam int COS_W   = 16;
    localparam int DEG_W   = 15;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;

    localparam int DIFF_W  = 33;
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 64;
    localparam int SUM_W   = 66;
    localparam int PROD_W  = 49;
    localparam int DOT_W   = 51;
    localparam int DMAG_W  = 49;
    localparam int TSQ_W   = 100;
    localparam int QUO_W   = 32;
    localparam int CX_W    = 34;
    localparam int ZA_W    = 26;
    localparam int ATAN_W  = 22;

    localparam int RANGE_STEPS  = 32;
    localparam int COS_STEPS    = 16;
    localparam int YSQ_STEPS    = 31;
    localparam int CORDIC_STEPS = 20;

    localparam logic [IDX_W-1:0] CFG_SCANNER_X = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SCANNER_Y = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SCANNER_Z = 2'd2;

    localparam logic [COS_W-1:0] COS_CLAMP = 16'd65529;
    localparam logic [DEG_W-1:0] DEG_MAX   = 15'd23040;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } t_sqrt_st;

    typedef struct packed {
        logic                valid;
        logic                vres;
        logic                sat;
        logic [SUM_W-1:0]    s;
        logic [SUM_W-1:0]    rem;
        logic [QUO_W-1:0]    tlo;
    } t_div_in;

    typedef struct packed {
        logic                valid;
        logic                vres;
        logic [RANGE_W-1:0]  range_v;
        logic [COS_W-1:0]    c;
    } t_ang_in;

    typedef struct packed {
        logic                valid;
        logic                vres;
        logic [RANGE_W-1:0]  range_v;
        logic [COS_W-1:0]    c;
        logic [DEG_W-1:0]    deg;
    } t_result;

    // One step of the digit-by-digit square root; b is the current bit (a power of four).
    function automatic t_sqrt_st sqrt_step(input t_sqrt_st s, input logic [63:0] b);
        t_sqrt_st    o;
        logic [63:0] t;
        t = s.root + b;
        if (s.rem >= t) begin
            o.rem  = s.rem - t;
            o.root = (s.root >> 1) + b;
        end else begin
            o.rem  = s.rem;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

    // Arctangent of 2^-i in 2^-16 degree.
    function automatic logic [ATAN_W-1:0] atan_val(input int i);
        logic [ATAN_W-1:0] v;
        case (i)
            0:  v = 22'd2949120;
            1:  v = 22'd1740967;
            2:  v = 22'd919879;
            3:  v = 22'd466945;
            4:  v = 22'd234379;
            5:  v = 22'd117304;
            6:  v = 22'd58666;
            7:  v = 22'd29335;
            8:  v = 22'd14668;
            9:  v = 22'd7334;
            10: v = 22'd3667;
            11: v = 22'd1833;
            12: v = 22'd917;
            13: v = 22'd458;
            14: v = 22'd229;
            15: v = 22'd115;
            16: v = 22'd57;
            17: v = 22'd29;
            18: v = 22'd14;
            19: v = 22'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/iaf_point_if.sv
// ----------------------------------------------------------------------------
// Point channel
// Valid/ready channel that carries one scan point and its unit normal.
// ----------------------------------------------------------------------------
interface iaf_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [iaf_pkg::COORD_W-1:0]  point_x;
    logic signed [iaf_pkg::COORD_W-1:0]  point_y;
    logic signed [iaf_pkg::COORD_W-1:0]  point_z;
    logic signed [iaf_pkg::NORM_W-1:0]   norm_x;
    logic signed [iaf_pkg::NORM_W-1:0]   norm_y;
    logic signed [iaf_pkg::NORM_W-1:0]   norm_z;

    modport source (output valid, point_x, point_y, point_z, norm_x, norm_y, norm_z,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, norm_x, norm_y, norm_z,
                    output ready);
endinterface

### hw/rtl/iaf_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries range, cosine and angle of one point.
// ----------------------------------------------------------------------------
interface iaf_result_if;
    logic                          valid;
    logic                          ready;
    logic [iaf_pkg::RANGE_W-1:0]   range_to_scanner;
    logic [iaf_pkg::COS_W-1:0]     cos_incidence;
    logic [iaf_pkg::DEG_W-1:0]     incidence_deg;
    logic                          valid_res;

    modport source (output valid, range_to_scanner, cos_incidence, incidence_deg, valid_res,
                    input ready);
    modport sink   (input valid, range_to_scanner, cos_incidence, incidence_deg, valid_res,
                    output ready);
endinterface

### hw/rtl/incidence_angle_from_normal.sv
// ----------------------------------------------------------------------------
// Lidar incidence angle unit
// Range, incidence cosine and incidence angle of scan points against a
// configured scanner position.
// ----------------------------------------------------------------------------
// One point transaction enters per clock and one result transaction leaves per
// clock while the output is not stalled. The chain holds 107 register stages,
// the last of which is the output register. The pipeline runs as one chain:
// six front stages (difference, squares and dot products, sums, split squaring
// of the dot product, sum, quotient range check), 32 stages of restoring
// division with the range square root beside it, 16 stages of square root of
// the quotient, one stage squaring the cosine, 31 square root stages for the
// sine, 20 CORDIC stages and the output register. The whole chain advances
// whenever the output register is empty or being drained, so a stall at the
// output freezes every stage and nothing is lost or repeated. The scanner
// position is written through the plain register port (index 0, 1, 2 for x,
// y, z; other indexes are ignored) and should only be changed while no point
// is in flight. A point that coincides with the scanner gives valid_res low
// and all other fields zero.
// ----------------------------------------------------------------------------
module incidence_angle_from_normal (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [iaf_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [iaf_pkg::CFG_W-1:0]       i_cfg_data,
    iaf_point_if.sink                       i_point,
    iaf_result_if.source                    o_result
);

    logic signed [iaf_pkg::COORD_W-1:0] r_scan_x, r_scan_y, r_scan_z;
    iaf_pkg::t_result                   r_out, n_out;
    iaf_pkg::t_div_in                   w_div;
    iaf_pkg::t_ang_in                   w_ang;
    iaf_pkg::t_result                   w_res;
    logic                               w_en;

    // Every stage moves when the output register can take a new entry.
    assign w_en          = !r_out.valid || o_result.ready;
    assign i_point.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_x <= '0;
            r_scan_y <= '0;
            r_scan_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                iaf_pkg::CFG_SCANNER_X: r_scan_x <= i_cfg_data;
                iaf_pkg::CFG_SCANNER_Y: r_scan_y <= i_cfg_data;
                iaf_pkg::CFG_SCANNER_Z: r_scan_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    iaf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_point.valid),
        .i_px    (i_point.point_x),
        .i_py    (i_point.point_y),
        .i_pz    (i_point.point_z),
        .i_nx    (i_point.norm_x),
        .i_ny    (i_point.norm_y),
        .i_nz    (i_point.norm_z),
        .i_sx    (r_scan_x),
        .i_sy    (r_scan_y),
        .i_sz    (r_scan_z),
        .o_div   (w_div)
    );

    iaf_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_div   (w_div),
        .o_ang   (w_ang)
    );

    iaf_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ang   (w_ang),
        .o_res   (w_res)
    );

    // A point on the scanner has no direction; all of its fields read zero.
    always_comb begin
        n_out         = w_res;
        if (!w_res.vres) begin
            n_out.range_v = '0;
            n_out.c       = '0;
            n_out.deg     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid            = r_out.valid;
    assign o_result.range_to_scanner = r_out.range_v;
    assign o_result.cos_incidence    = r_out.c;
    assign o_result.incidence_deg    = r_out.deg;
    assign o_result.valid_res        = r_out.vres;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.valid_res) |->
        (o_result.range_to_scanner == '0 && o_result.cos_incidence == '0 &&
         o_result.incidence_deg == '0))
        else $error("invalid point with nonzero fields");

    a_range_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.valid_res) |-> (o_result.range_to_scanner != '0))
        else $error("valid point with zero range");

    a_deg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.incidence_deg <= iaf_pkg::DEG_MAX))
        else $error("incidence angle above 90 degrees");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_out))
        else $error("output register changed during stall");
`endif

endmodule

### hw/rtl/iaf_front.sv
// ----------------------------------------------------------------------------
// Incidence angle front end
// Differences, squares, dot product, squared dot product and the first
// quotient compare, over six register stages.
// ----------------------------------------------------------------------------
module iaf_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [iaf_pkg::COORD_W-1:0]  i_px,
    input  logic signed [iaf_pkg::COORD_W-1:0]  i_py,
    input  logic signed [iaf_pkg::COORD_W-1:0]  i_pz,
    input  logic signed [iaf_pkg::NORM_W-1:0]   i_nx,
    input  logic signed [iaf_pkg::NORM_W-1:0]   i_ny,
    input  logic signed [iaf_pkg::NORM_W-1:0]   i_nz,
    input  logic signed [iaf_pkg::COORD_W-1:0]  i_sx,
    input  logic signed [iaf_pkg::COORD_W-1:0]  i_sy,
    input  logic signed [iaf_pkg::COORD_W-1:0]  i_sz,
    output iaf_pkg::t_div_in                    o_div
);

    typedef struct packed {
        logic                               valid;
        logic signed [2:0][iaf_pkg::DIFF_W-1:0] d;
        logic signed [2:0][iaf_pkg::NORM_W-1:0] n;
    } t_sa;

    typedef struct packed {
        logic                               valid;
        logic [2:0][iaf_pkg::SQ_W-1:0]      sq;
        logic [2:0][iaf_pkg::PROD_W-1:0]    pr;
    } t_sb;

    typedef struct packed {
        logic                         valid;
        logic [iaf_pkg::SUM_W-1:0]    s;
        logic signed [iaf_pkg::DOT_W-1:0] dot;
    } t_sc;

    typedef struct packed {
        logic                         valid;
        logic [iaf_pkg::SUM_W-1:0]    s;
        logic [47:0]                  hh;
        logic [48:0]                  hl;
        logic [49:0]                  ll;
    } t_sd;

    typedef struct packed {
        logic                         valid;
        logic [iaf_pkg::SUM_W-1:0]    s;
        logic [iaf_pkg::TSQ_W-1:0]    t;
    } t_se;

    t_sa r_a, n_a;
    t_sb r_b, n_b;
    t_sc r_c, n_c;
    t_sd r_d, n_d;
    t_se r_e, n_e;
    iaf_pkg::t_div_in r_f, n_f;

    logic signed [iaf_pkg::DIFF_W-1:0] w_d   [3];
    logic [iaf_pkg::MAG_W-1:0]         w_mag [3];
    logic signed [iaf_pkg::DOT_W-1:0]  w_dneg;
    logic [iaf_pkg::DMAG_W-1:0]        w_dmag;
    logic [97:0]                       w_sq98;
    logic [67:0]                       w_thi;

    function automatic logic signed [iaf_pkg::DIFF_W-1:0] DIFF_W_SX(
        input logic signed [iaf_pkg::COORD_W-1:0] v);
        return {v[iaf_pkg::COORD_W-1], v};
    endfunction

    always_comb begin
        n_a.valid = i_valid;
        n_a.d[0]  = DIFF_W_SX(i_px) - DIFF_W_SX(i_sx);
        n_a.d[1]  = DIFF_W_SX(i_py) - DIFF_W_SX(i_sy);
        n_a.d[2]  = DIFF_W_SX(i_pz) - DIFF_W_SX(i_sz);
        n_a.n[0]  = i_nx;
        n_a.n[1]  = i_ny;
        n_a.n[2]  = i_nz;
    end

    always_comb begin
        n_b.valid = r_a.valid;
        for (int j = 0; j < 3; j++) begin
            w_d[j]   = r_a.d[j];
            w_mag[j] = w_d[j][iaf_pkg::DIFF_W-1] ? iaf_pkg::MAG_W'(-w_d[j])
                                                 : iaf_pkg::MAG_W'(w_d[j]);
            n_b.sq[j] = iaf_pkg::SQ_W'(w_mag[j]) * iaf_pkg::SQ_W'(w_mag[j]);
            n_b.pr[j] = iaf_pkg::PROD_W'($signed(r_a.n[j]) * w_d[j]);
        end
    end

    always_comb begin
        n_c.valid = r_b.valid;
        n_c.s     = iaf_pkg::SUM_W'(r_b.sq[0]) + iaf_pkg::SUM_W'(r_b.sq[1])
                  + iaf_pkg::SUM_W'(r_b.sq[2]);
        n_c.dot   = iaf_pkg::DOT_W'($signed(r_b.pr[0])) + iaf_pkg::DOT_W'($signed(r_b.pr[1]))
                  + iaf_pkg::DOT_W'($signed(r_b.pr[2]));
    end

    always_comb begin
        w_dneg    = -r_c.dot;
        w_dmag    = r_c.dot[iaf_pkg::DOT_W-1] ? iaf_pkg::DMAG_W'(w_dneg)
                                              : iaf_pkg::DMAG_W'(r_c.dot);
        n_d.valid = r_c.valid;
        n_d.s     = r_c.s;
        n_d.hh    = 48'(w_dmag[48:25]) * 48'(w_dmag[48:25]);
        n_d.hl    = 49'(w_dmag[48:25]) * 49'(w_dmag[24:0]);
        n_d.ll    = 50'(w_dmag[24:0]) * 50'(w_dmag[24:0]);
    end

    always_comb begin
        // The dot product is Q15 times the coordinate, so the squared ratio is scaled by 4.
        w_sq98    = {r_d.hh, 50'b0} + 98'({r_d.hl, 26'b0}) + 98'(r_d.ll);
        n_e.valid = r_d.valid;
        n_e.s     = r_d.s;
        n_e.t     = {w_sq98, 2'b00};
    end

    always_comb begin
        w_thi     = r_e.t[99:32];
        n_f.valid = r_e.valid;
        n_f.vres  = |r_e.s;
        n_f.s     = r_e.s;
        n_f.sat   = (w_thi >= {2'b00, r_e.s});
        n_f.rem   = n_f.sat ? '0 : w_thi[iaf_pkg::SUM_W-1:0];
        n_f.tlo   = r_e.t[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_d.valid <= 1'b0;
            r_e.valid <= 1'b0;
            r_f.valid <= 1'b0;
        end else if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            r_e <= n_e;
            r_f <= n_f;
        end
    end

    assign o_div = r_f;

endmodule

### hw/rtl/iaf_divsqrt.sv
// ----------------------------------------------------------------------------
// Incidence angle divider and square roots
// Restoring division of the squared dot product by the squared distance,
// the range square root alongside it, then the square root of the quotient.
// ----------------------------------------------------------------------------
module iaf_divsqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  iaf_pkg::t_div_in  i_div,
    output iaf_pkg::t_ang_in  o_ang
);

    typedef struct packed {
        iaf_pkg::t_div_in           dv;
        logic [iaf_pkg::QUO_W-1:0]  q;
        iaf_pkg::t_sqrt_st          rs;
    } t_dst;

    typedef struct packed {
        logic                         valid;
        logic                         vres;
        logic                         sat;
        logic [iaf_pkg::RANGE_W-1:0]  range_v;
        iaf_pkg::t_sqrt_st            cs;
    } t_cst;

    t_dst r_ds [iaf_pkg::RANGE_STEPS];
    t_cst r_cs [iaf_pkg::COS_STEPS];

    for (genvar i = 0; i < iaf_pkg::RANGE_STEPS; i++) begin : g_div
        localparam logic [63:0] BitV = 64'd1 << (2 * (iaf_pkg::RANGE_STEPS - 1 - i));
        t_dst                       p, n_ds;
        logic [iaf_pkg::SUM_W:0]    sh;

        always_comb begin
            if (i == 0) begin
                p.dv         = i_div;
                p.q          = '0;
                p.rs.rem     = i_div.s[63:0];
                p.rs.root    = '0;
            end else begin
                p = r_ds[(i == 0) ? 0 : i - 1];
            end
            sh           = {p.dv.rem, p.dv.tlo[iaf_pkg::QUO_W-1]};
            n_ds         = p;
            n_ds.dv.tlo  = {p.dv.tlo[iaf_pkg::QUO_W-2:0], 1'b0};
            if (sh >= {1'b0, p.dv.s}) begin
                n_ds.dv.rem = iaf_pkg::SUM_W'(sh - {1'b0, p.dv.s});
                n_ds.q      = {p.q[iaf_pkg::QUO_W-2:0], 1'b1};
            end else begin
                n_ds.dv.rem = sh[iaf_pkg::SUM_W-1:0];
                n_ds.q      = {p.q[iaf_pkg::QUO_W-2:0], 1'b0};
            end
            n_ds.rs      = iaf_pkg::sqrt_step(p.rs, BitV);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ds[i].dv.valid <= 1'b0;
            end else if (i_en) begin
                r_ds[i] <= n_ds;
            end
        end
    end

    for (genvar i = 0; i < iaf_pkg::COS_STEPS; i++) begin : g_cos
        localparam logic [63:0] BitV = 64'd1 << (2 * (iaf_pkg::COS_STEPS - 1 - i));
        t_cst p, n_cs;
        t_dst l;

        always_comb begin
            l = r_ds[iaf_pkg::RANGE_STEPS - 1];
            if (i == 0) begin
                p.valid   = l.dv.valid;
                p.vres    = l.dv.vres;
                p.sat     = l.dv.sat;
                // A squared distance beyond 64 bits saturates the range.
                p.range_v = (|l.dv.s[iaf_pkg::SUM_W-1:64]) ? '1
                                                           : l.rs.root[iaf_pkg::RANGE_W-1:0];
                p.cs.rem  = {32'b0, l.q};
                p.cs.root = '0;
            end else begin
                p = r_cs[(i == 0) ? 0 : i - 1];
            end
            n_cs    = p;
            n_cs.cs = iaf_pkg::sqrt_step(p.cs, BitV);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cs[i].valid <= 1'b0;
            end else if (i_en) begin
                r_cs[i] <= n_cs;
            end
        end
    end

    always_comb begin
        o_ang.valid   = r_cs[iaf_pkg::COS_STEPS - 1].valid;
        o_ang.vres    = r_cs[iaf_pkg::COS_STEPS - 1].vres;
        o_ang.range_v = r_cs[iaf_pkg::COS_STEPS - 1].range_v;
        o_ang.c       = r_cs[iaf_pkg::COS_STEPS - 1].sat ? iaf_pkg::COS_CLAMP
                      : r_cs[iaf_pkg::COS_STEPS - 1].cs.root[iaf_pkg::COS_W-1:0];
    end

endmodule

### hw/rtl/iaf_angle.sv
// ----------------------------------------------------------------------------
// Incidence angle arccosine
// Sine from the cosine by a pipelined square root, then a CORDIC vectoring
// pipeline that accumulates the angle.
// ----------------------------------------------------------------------------
module iaf_angle (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  iaf_pkg::t_ang_in  i_ang,
    output iaf_pkg::t_result  o_res
);

    typedef struct packed {
        iaf_pkg::t_ang_in   a;
        iaf_pkg::t_sqrt_st  ys;
    } t_yst;

    typedef struct packed {
        iaf_pkg::t_ang_in                  a;
        logic signed [iaf_pkg::CX_W-1:0]   x;
        logic signed [iaf_pkg::CX_W-1:0]   y;
        logic signed [iaf_pkg::ZA_W-1:0]   z;
    } t_cor;

    t_yst r_sq, n_sq;
    t_yst r_ys  [iaf_pkg::YSQ_STEPS];
    t_cor r_cor [iaf_pkg::CORDIC_STEPS];

    logic [32:0]                     w_csq;
    logic signed [iaf_pkg::ZA_W:0]   w_zr;
    logic [iaf_pkg::ZA_W-9:0]        w_zs;

    always_comb begin
        // One minus the squared cosine in Q32, moved up to Q60.
        w_csq      = 33'(i_ang.c) * 33'(i_ang.c);
        n_sq.a     = i_ang;
        n_sq.ys.rem  = 64'(33'h1_0000_0000 - w_csq) << 28;
        n_sq.ys.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.a.valid <= 1'b0;
        end else if (i_en) begin
            r_sq <= n_sq;
        end
    end

    for (genvar i = 0; i < iaf_pkg::YSQ_STEPS; i++) begin : g_ysq
        localparam logic [63:0] BitV = 64'd1 << (2 * (iaf_pkg::YSQ_STEPS - 1 - i));
        t_yst p, n_ys;

        always_comb begin
            p       = (i == 0) ? r_sq : r_ys[(i == 0) ? 0 : i - 1];
            n_ys    = p;
            n_ys.ys = iaf_pkg::sqrt_step(p.ys, BitV);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ys[i].a.valid <= 1'b0;
            end else if (i_en) begin
                r_ys[i] <= n_ys;
            end
        end
    end

    for (genvar i = 0; i < iaf_pkg::CORDIC_STEPS; i++) begin : g_cor
        localparam logic [iaf_pkg::ATAN_W-1:0] AtanV = iaf_pkg::atan_val(i);
        t_cor p, n_cor;
        t_yst l;
        logic signed [iaf_pkg::CX_W-1:0] xs, ys;

        always_comb begin
            l = r_ys[iaf_pkg::YSQ_STEPS - 1];
            if (i == 0) begin
                p.a = l.a;
                p.x = iaf_pkg::CX_W'({l.a.c, 14'b0});
                p.y = iaf_pkg::CX_W'(l.ys.root[31:0]);
                p.z = '0;
            end else begin
                p = r_cor[(i == 0) ? 0 : i - 1];
            end
            xs    = p.x >>> i;
            ys    = p.y >>> i;
            n_cor = p;
            if (p.y > 0) begin
                n_cor.x = p.x + ys;
                n_cor.y = p.y - xs;
                n_cor.z = p.z + iaf_pkg::ZA_W'(AtanV);
            end else begin
                n_cor.x = p.x - ys;
                n_cor.y = p.y + xs;
                n_cor.z = p.z - iaf_pkg::ZA_W'(AtanV);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cor[i].a.valid <= 1'b0;
            end else if (i_en) begin
                r_cor[i] <= n_cor;
            end
        end
    end

    always_comb begin
        // Round to 1/256 degree; anything not above zero gives zero.
        w_zr = (iaf_pkg::ZA_W + 1)'(r_cor[iaf_pkg::CORDIC_STEPS - 1].z) + 27'sd128;
        w_zs = w_zr[iaf_pkg::ZA_W-1:8];
        o_res.valid   = r_cor[iaf_pkg::CORDIC_STEPS - 1].a.valid;
        o_res.vres    = r_cor[iaf_pkg::CORDIC_STEPS - 1].a.vres;
        o_res.range_v = r_cor[iaf_pkg::CORDIC_STEPS - 1].a.range_v;
        o_res.c       = r_cor[iaf_pkg::CORDIC_STEPS - 1].a.c;
        if (w_zr[iaf_pkg::ZA_W]) begin
            o_res.deg = '0;
        end else if (w_zs > (iaf_pkg::ZA_W - 8)'(iaf_pkg::DEG_MAX)) begin
            o_res.deg = iaf_pkg::DEG_MAX;
        end else begin
            o_res.deg = iaf_pkg::DEG_W'(w_zs);
        end
    end

endmodule
